@@ hdl/seven_segment_scan_driver_top_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros shared by the display driver modules
// ---------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_SCAN_DRIVER_TOP_MACROS_SVH
`define SEVEN_SEGMENT_SCAN_DRIVER_TOP_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define SSD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("display driver assertion failed");

// Check that a condition is followed by another in the next cycle
`define SSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("display driver sequence assertion failed");

`endif

@@ hdl/ssd_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssd_pkg
// Shared types, codes and segment tables of the seven-segment scan driver.
// ---------------------------------------------------------------------------
package ssd_pkg;

   // request operation codes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // decimal point position in a segment byte
   localparam int DOT_BIT = 7;
   localparam logic [7:0] DOT_MASK = 8'h80;

   // reciprocal of ten for a 32-bit dividend, quotient = (v * RECIP_TEN) >> 35
   localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
   localparam int RECIP_SHIFT = 35;

   // classified request passed from the front end to the back end
   typedef struct packed {
      logic        is_tick;
      logic [31:0] value;
      logic [2:0]  dot_position;
   } cmd_type;

   // common cathode pattern of one decimal digit, segment a in bit 0
   function automatic logic [7:0] seg_cathode(input logic [3:0] digit);
      logic [7:0] pat;
      case (digit)
         4'd0: pat = 8'b0011_1111;
         4'd1: pat = 8'b0000_0110;
         4'd2: pat = 8'b0101_1011;
         4'd3: pat = 8'b0100_1111;
         4'd4: pat = 8'b0110_0110;
         4'd5: pat = 8'b0110_1101;
         4'd6: pat = 8'b0111_1101;
         4'd7: pat = 8'b0000_0111;
         4'd8: pat = 8'b0111_1111;
         4'd9: pat = 8'b0110_1111;
         default: pat = 8'b0000_0000;
      endcase
      return pat;
   endfunction

   // common anode pattern of one decimal digit
   function automatic logic [7:0] seg_anode(input logic [3:0] digit);
      logic [7:0] pat;
      case (digit)
         4'd0: pat = 8'b1100_0000;
         4'd1: pat = 8'b1111_1001;
         4'd2: pat = 8'b1010_0100;
         4'd3: pat = 8'b1011_0000;
         4'd4: pat = 8'b1001_1001;
         4'd5: pat = 8'b1001_0010;
         4'd6: pat = 8'b1000_0010;
         4'd7: pat = 8'b1111_1000;
         4'd8: pat = 8'b1000_0000;
         4'd9: pat = 8'b1001_0000;
         default: pat = 8'b1111_1111;
      endcase
      return pat;
   endfunction

endpackage

@@ hdl/ssd_front.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssd_front
// Accepts requests, classifies them as load or tick and queues up to two
// classified requests for the back end.
// ---------------------------------------------------------------------------
`include "seven_segment_scan_driver_top_macros.svh"

module ssd_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic            req_op,
   input  logic [31:0]     req_value,
   input  logic [2:0]      req_dot_position,
   output logic            cmd_valid,
   input  logic            cmd_ready,
   output ssd_pkg::cmd_type cmd
);
   import ssd_pkg::*;

   cmd_type    queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;
   cmd_type    entry;

   // classify the incoming request
   always_comb begin
      entry.is_tick      = (req_op == OP_TICK);
      entry.value        = req_value;
      entry.dot_position = req_dot_position;
   end

   assign req_ready = (count_ff != 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = queue_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   // advance pointers and fill count
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the classified request
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

   `SSD_ASSERT(a_count_range, clock, reset, count_ff <= 2'd2)
   `SSD_ASSERT_NEXT(a_fill_to_full, clock, reset, (count_ff == 2'd1) && push && !pop, !req_ready)

endmodule

@@ hdl/ssd_back.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssd_back
// Carries out queued requests: a load splits the value into decimal digits,
// one per cycle, and stores their patterns; a tick emits the select and
// segment bytes of the current digit and advances the scan index.
// ---------------------------------------------------------------------------
`include "seven_segment_scan_driver_top_macros.svh"

module ssd_back #(
   parameter int DIGITS = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             anode_mode,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  ssd_pkg::cmd_type cmd,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_digit_select,
   output logic [7:0]       rsp_segment_pattern
);
   import ssd_pkg::*;

   localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIGITS - 1);
   localparam logic [7:0] ALL_MASK = 8'((16'd1 << DIGITS) - 16'd1);

   logic [7:0]       store_ff [DIGITS];
   logic [IDX_W-1:0] scan_ff, scan_in;
   logic [IDX_W-1:0] digit_ff, digit_in;
   logic             busy_ff, busy_in;
   logic [31:0]      value_ff, value_in;
   logic [2:0]       dot_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       sel_ff, sel_in;
   logic [7:0]       seg_ff;
   logic             load_pop, tick_pop, out_free;
   logic [63:0]      product;
   logic [31:0]      quotient;
   logic [31:0]      remainder;
   logic [7:0]       digit_pat;
   logic [7:0]       one_hot;

   // take a request only when no load runs; a tick also needs a free output
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cmd_ready = !busy_ff && (!cmd.is_tick || out_free);
   assign load_pop  = cmd_valid && cmd_ready && !cmd.is_tick;
   assign tick_pop  = cmd_valid && cmd_ready && cmd.is_tick;

   // divide the remaining value by ten and form the digit pattern
   always_comb begin
      product   = 64'(value_ff) * 64'(RECIP_TEN);
      quotient  = 32'(product >> RECIP_SHIFT);
      remainder = value_ff - (quotient << 3) - (quotient << 1);
      digit_pat = anode_mode ? seg_anode(remainder[3:0]) : seg_cathode(remainder[3:0]);
      if (3'(digit_ff) == dot_ff) begin
         if (anode_mode) begin
            digit_pat = digit_pat & ~DOT_MASK;
         end else begin
            digit_pat = digit_pat | DOT_MASK;
         end
      end
   end

   // sequence the digit extraction
   always_comb begin
      busy_in  = busy_ff;
      digit_in = digit_ff;
      value_in = value_ff;
      if (load_pop) begin
         busy_in  = 1'b1;
         digit_in = '0;
         value_in = cmd.value;
      end else if (busy_ff) begin
         value_in = quotient;
         if (digit_ff == LAST_IDX) begin
            busy_in  = 1'b0;
            digit_in = '0;
         end else begin
            digit_in = digit_ff + 1'b1;
         end
      end
   end

   // build the select byte and advance the scan index
   always_comb begin
      one_hot = 8'd1 << scan_ff;
      sel_in  = anode_mode ? one_hot : (ALL_MASK & ~one_hot);
      scan_in = scan_ff;
      if (tick_pop) begin
         scan_in = (scan_ff == LAST_IDX) ? '0 : scan_ff + 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (tick_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         digit_ff     <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         digit_ff     <= digit_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the value under division and the dot position
   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (load_pop) begin
         dot_ff <= cmd.dot_position;
      end
   end

   // write one digit pattern per cycle of a load
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIGITS; i++) begin
            store_ff[i] <= 8'd0;
         end
      end else if (busy_ff) begin
         store_ff[digit_ff] <= digit_pat;
      end
   end

   // register the response bytes
   always_ff @(posedge clock) begin
      if (tick_pop) begin
         sel_ff <= sel_in;
         seg_ff <= store_ff[scan_ff];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_digit_select    = sel_ff;
   assign rsp_segment_pattern = seg_ff;

   `SSD_ASSERT(a_digit_range, clock, reset, busy_ff |-> (int'(digit_ff) < DIGITS))
   `SSD_ASSERT(a_no_take_busy, clock, reset, busy_ff |-> !cmd_ready)
   `SSD_ASSERT_NEXT(a_load_starts, clock, reset, load_pop, busy_ff)
   `SSD_ASSERT_NEXT(a_tick_responds, clock, reset, tick_pop, rsp_valid_ff)

endmodule

@@ hdl/seven_segment_scan_driver_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// seven_segment_scan_driver_top
// Multiplexed seven-segment display driver with load and scan requests.
// ---------------------------------------------------------------------------
// A request is either a load of a new 32-bit value or a scan tick. The
// select and segment bytes of a tick appear on the registered response
// port in the cycle after the back end takes it; ticks stream one per
// cycle while responses are taken and no load is in progress. A load
// produces no response and holds the back end while a shared divide-by-ten
// unit forms its digits, one per cycle. A two-entry queue from the request
// side to the back end keeps requests flowing during a load. Polarity is a
// one-bit register written on the csr port; the user must write it only
// while idle, which the block does not enforce; stored patterns keep the
// polarity in force when loaded.
module seven_segment_scan_driver_top #(
   parameter int DIGITS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_anode_mode,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [31:0] req_value,
   input  logic [2:0]  req_dot_position,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_digit_select,
   output logic [7:0]  rsp_segment_pattern
);
   import ssd_pkg::*;

   logic    anode_mode_ff, anode_mode_in;
   logic    cmd_valid, cmd_ready;
   cmd_type cmd;

   // hold the polarity register
   assign csr_ready     = 1'b1;
   assign anode_mode_in = (csr_valid && csr_ready) ? csr_anode_mode : anode_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         anode_mode_ff <= 1'b0;
      end else begin
         anode_mode_ff <= anode_mode_in;
      end
   end

   ssd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_value        (req_value),
      .req_dot_position (req_dot_position),
      .cmd_valid        (cmd_valid),
      .cmd_ready        (cmd_ready),
      .cmd              (cmd)
   );

   ssd_back #(
      .DIGITS (DIGITS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .anode_mode          (anode_mode_ff),
      .cmd_valid           (cmd_valid),
      .cmd_ready           (cmd_ready),
      .cmd                 (cmd),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_digit_select    (rsp_digit_select),
      .rsp_segment_pattern (rsp_segment_pattern)
   );

endmodule
